// File: hdl/bca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_pkg: shared constants for the bitmap chunk allocator
// Field widths, status and opcode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bca_pkg;

    localparam int WORD_BITS     = 32;
    localparam int OFF_W         = 5;
    localparam int HEADER_BYTES  = 8;
    localparam int MAX_RUN       = 32;
    localparam int STORE_DEPTH   = 2048;
    localparam int DEF_MAP_WORDS = 64;

    localparam int STATUS_W   = 2;
    localparam int START_W    = 11;
    localparam int RUN_W      = 6;
    localparam int SEQ_W      = 32;
    localparam int LIVE_W     = 12;
    localparam int REQ_W      = 20;
    localparam int BYTES_W    = REQ_W + 1;
    localparam int SHIFT_W    = 4;
    localparam int ACTIVE_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SHIFT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WORDS = 1'd1;

    localparam logic [SHIFT_W-1:0]  CHUNK_SHIFT_RST  = 4'd6;
    localparam logic [ACTIVE_W-1:0] ACTIVE_WORDS_RST = 7'd64;

    localparam logic [LIVE_W-1:0] LIVE_MAX = {LIVE_W{1'b1}};

endpackage

// File: hdl/bitmap_chunk_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_chunk_allocator: first-fit chunk allocator over a used-bit map
// Usage: configure with cfg_we/cfg_index/cfg_data while idle (index 0 is the
// chunk shift, index 1 the active map word count). Items enter on the req
// channel (req_valid, req_stall) and each gives one result on the rsp channel
// (rsp_valid, rsp_stall). An allocate sizes the request in S_SIZE, then
// scans one map word per cycle through the map memory read port in S_SCAN
// and commits in S_COMMIT before S_DONE loads the output register. A free
// reads the map word and run length in S_FREE_RD, writes back in S_FREE_WR
// and loads the output register in S_DONE. One item is in work at a time;
// req_stall is high while it is. After reset the map memory is cleared one
// word per cycle with req_stall high; configuration writes are taken during
// that pass. A result waiting under rsp_stall holds in the output register
// while the next item is accepted and worked on; that item then waits at its
// end until the register frees.
// ----------------------------------------------------------------------------
module bitmap_chunk_allocator #(
    parameter int MAP_WORDS = bca_pkg::DEF_MAP_WORDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bca_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              opcode,
    input  logic [bca_pkg::REQ_W-1:0]         request_bytes,
    input  logic [bca_pkg::START_W-1:0]       free_start_chunk,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [bca_pkg::STATUS_W-1:0]      status,
    output logic [bca_pkg::START_W-1:0]       start_chunk,
    output logic [bca_pkg::RUN_W-1:0]         run_chunks,
    output logic [bca_pkg::SEQ_W-1:0]        alloc_sequence,
    output logic [bca_pkg::LIVE_W-1:0]        live_objects
);
    import bca_pkg::*;

    localparam int WIDX  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W = $clog2(MAP_WORDS + 1);
    localparam int AW    = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
    localparam int FW    = (CNT_W + OFF_W > START_W) ? CNT_W + OFF_W : START_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SIZE, S_SCAN, S_COMMIT, S_FREE_RD, S_FREE_WR, S_DONE
    } state_t;

    // memories
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [RUN_W-1:0]     len_mem [STORE_DEPTH];
    logic [WORD_BITS-1:0] map_rd;
    logic [RUN_W-1:0]     len_rd;
    logic [WIDX-1:0]      map_ra;
    logic [WIDX-1:0]      map_wa;
    logic [WORD_BITS-1:0] map_wd;
    logic                 map_we;
    logic                 len_we;

    // registers
    state_t               state_reg, state_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic [ACTIVE_W-1:0]  active_reg, active_next;
    logic [WIDX-1:0]      clr_idx_reg, clr_idx_next;
    logic [REQ_W-1:0]     bytes_reg, bytes_next;
    logic [START_W-1:0]   fstart_reg, fstart_next;
    logic [RUN_W-1:0]     need_reg, need_next;
    logic [WORD_BITS-1:0] run_lo_reg, run_lo_next;
    logic [CNT_W-1:0]     issue_idx_reg, issue_idx_next;
    logic                 pend_reg, pend_next;
    logic [WIDX-1:0]      pend_idx_reg, pend_idx_next;
    logic [WIDX-1:0]      hit_word_reg, hit_word_next;
    logic [OFF_W-1:0]     hit_b_reg, hit_b_next;
    logic [WORD_BITS-1:0] hit_data_reg, hit_data_next;
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic [LIVE_W-1:0]    live_reg, live_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [START_W-1:0]   res_start_reg, res_start_next;
    logic [RUN_W-1:0]     res_run_reg, res_run_next;
    logic [SEQ_W-1:0]     res_seq_reg, res_seq_next;
    logic [LIVE_W-1:0]    res_live_reg, res_live_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [START_W-1:0]   out_start_reg, out_start_next;
    logic [RUN_W-1:0]     out_run_reg, out_run_next;
    logic [SEQ_W-1:0]     out_seq_reg, out_seq_next;
    logic [LIVE_W-1:0]    out_live_reg, out_live_next;

    // combinational helpers
    logic [CNT_W-1:0]     words;
    logic [FW-1:0]        free_limit;
    logic                 free_outside;
    logic                 issue_en;
    logic [WORD_BITS-1:0] fits;
    logic [OFF_W-1:0]     first_b;
    logic                 hit;
    logic [WORD_BITS-1:0] alloc_mask;
    logic [WORD_BITS-1:0] free_mask;
    logic [START_W-1:0]   alloc_start;
    logic [WIDX-1:0]      free_word;
    logic [BYTES_W-1:0]   size_bytes;
    logic [BYTES_W-1:0]   size_need;
    logic                 size_rem;
    logic                 out_free;

    assign words = (AW'(active_reg) > AW'(MAP_WORDS)) ? CNT_W'(MAP_WORDS)
                                                      : CNT_W'(active_reg);
    assign free_limit   = FW'(words) << OFF_W;
    assign free_outside = FW'(free_start_chunk) >= free_limit;
    assign issue_en     = issue_idx_reg < words;
    assign alloc_start  = START_W'({hit_word_reg, hit_b_reg});
    assign free_word    = WIDX'(fstart_reg >> OFF_W);
    assign out_free     = !out_valid_reg || !rsp_stall;
    assign hit          = pend_reg && (|fits);

    assign size_bytes = {1'b0, bytes_reg} + BYTES_W'(HEADER_BYTES);
    assign size_rem   = |(size_bytes & ((BYTES_W'(1) << shift_reg) - BYTES_W'(1)));
    assign size_need  = (size_bytes >> shift_reg) + BYTES_W'(size_rem);

    always_comb
    begin
        logic [2*WORD_BITS-1:0] m;
        m       = '0;
        fits    = '0;
        first_b = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            m       = {{WORD_BITS{1'b0}}, run_lo_reg} << b;
            fits[b] = (m[2*WORD_BITS-1:WORD_BITS] == '0) && ((map_rd & m[WORD_BITS-1:0]) == '0);
        end
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (fits[b])
            begin
                first_b = OFF_W'(b);
            end
        end
    end

    always_comb
    begin
        logic [2*WORD_BITS-1:0] am;
        logic [2*WORD_BITS-1:0] fm;
        am         = {{WORD_BITS{1'b0}}, run_lo_reg} << hit_b_reg;
        alloc_mask = am[WORD_BITS-1:0];
        fm         = ((64'd1 << len_rd) - 64'd1) << fstart_reg[OFF_W-1:0];
        free_mask  = fm[WORD_BITS-1:0];
    end

    always_comb
    begin
        logic [WORD_BITS:0] lo;
        state_next      = state_reg;
        shift_next      = shift_reg;
        active_next     = active_reg;
        clr_idx_next    = clr_idx_reg;
        bytes_next      = bytes_reg;
        fstart_next     = fstart_reg;
        need_next       = need_reg;
        run_lo_next     = run_lo_reg;
        issue_idx_next  = issue_idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hit_word_next   = hit_word_reg;
        hit_b_next      = hit_b_reg;
        hit_data_next   = hit_data_reg;
        seq_next        = seq_reg;
        live_next       = live_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_run_next    = res_run_reg;
        res_seq_next    = res_seq_reg;
        res_live_next   = res_live_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_run_next    = out_run_reg;
        out_seq_next    = out_seq_reg;
        out_live_next   = out_live_reg;
        map_ra          = '0;
        map_wa          = hit_word_reg;
        map_wd          = hit_data_reg | alloc_mask;
        map_we          = 1'b0;
        len_we          = 1'b0;
        lo              = ((WORD_BITS+1)'(1) << size_need[RUN_W-1:0]) - (WORD_BITS+1)'(1);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHUNK_SHIFT:  shift_next  = cfg_data[SHIFT_W-1:0];
                CFG_ACTIVE_WORDS: active_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                map_wa       = clr_idx_reg;
                map_wd       = '0;
                map_we       = 1'b1;
                clr_idx_next = clr_idx_reg + WIDX'(1);
                if (clr_idx_reg == WIDX'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    bytes_next  = request_bytes;
                    fstart_next = free_start_chunk;
                    if (opcode == OP_ALLOC)
                    begin
                        state_next = S_SIZE;
                    end
                    else if (free_outside)
                    begin
                        res_status_next = ST_BAD_FREE;
                        res_start_next  = '0;
                        res_run_next    = '0;
                        res_seq_next    = '0;
                        res_live_next   = live_reg;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_SIZE:
            begin
                need_next      = size_need[RUN_W-1:0];
                run_lo_next    = lo[WORD_BITS-1:0];
                issue_idx_next = '0;
                if (size_need > BYTES_W'(MAX_RUN))
                begin
                    res_status_next = ST_NO_SPACE;
                    res_start_next  = '0;
                    res_run_next    = '0;
                    res_seq_next    = '0;
                    res_live_next   = live_reg;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                map_ra        = WIDX'(issue_idx_reg);
                pend_next     = issue_en;
                pend_idx_next = WIDX'(issue_idx_reg);
                if (issue_en)
                begin
                    issue_idx_next = issue_idx_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    hit_word_next = pend_idx_reg;
                    hit_b_next    = first_b;
                    hit_data_next = map_rd;
                    state_next    = S_COMMIT;
                end
                else if (!issue_en)
                begin
                    res_status_next = ST_NO_SPACE;
                    res_start_next  = '0;
                    res_run_next    = '0;
                    res_seq_next    = '0;
                    res_live_next   = live_reg;
                    state_next      = S_DONE;
                end
            end
            S_COMMIT:
            begin
                map_we          = 1'b1;
                len_we          = 1'b1;
                seq_next        = seq_reg + SEQ_W'(1);
                live_next       = (live_reg == LIVE_MAX) ? live_reg : live_reg + LIVE_W'(1);
                res_status_next = ST_OK;
                res_start_next  = alloc_start;
                res_run_next    = need_reg;
                res_seq_next    = seq_reg;
                res_live_next   = live_next;
                state_next      = S_DONE;
            end
            S_FREE_RD:
            begin
                map_ra     = free_word;
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                map_wa          = free_word;
                map_wd          = map_rd & ~free_mask;
                map_we          = 1'b1;
                live_next       = (live_reg == '0) ? live_reg : live_reg - LIVE_W'(1);
                res_status_next = ST_OK;
                res_start_next  = fstart_reg;
                res_run_next    = len_rd;
                res_seq_next    = '0;
                res_live_next   = live_next;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_run_next    = res_run_reg;
                    out_seq_next    = res_seq_reg;
                    out_live_next   = res_live_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            shift_reg      <= CHUNK_SHIFT_RST;
            active_reg     <= ACTIVE_WORDS_RST;
            clr_idx_reg    <= '0;
            bytes_reg      <= '0;
            fstart_reg     <= '0;
            need_reg       <= '0;
            run_lo_reg     <= '0;
            issue_idx_reg  <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            hit_word_reg   <= '0;
            hit_b_reg      <= '0;
            hit_data_reg   <= '0;
            seq_reg        <= '0;
            live_reg       <= '0;
            res_status_reg <= ST_OK;
            res_start_reg  <= '0;
            res_run_reg    <= '0;
            res_seq_reg    <= '0;
            res_live_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_start_reg  <= '0;
            out_run_reg    <= '0;
            out_seq_reg    <= '0;
            out_live_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            shift_reg      <= shift_next;
            active_reg     <= active_next;
            clr_idx_reg    <= clr_idx_next;
            bytes_reg      <= bytes_next;
            fstart_reg     <= fstart_next;
            need_reg       <= need_next;
            run_lo_reg     <= run_lo_next;
            issue_idx_reg  <= issue_idx_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            hit_word_reg   <= hit_word_next;
            hit_b_reg      <= hit_b_next;
            hit_data_reg   <= hit_data_next;
            seq_reg        <= seq_next;
            live_reg       <= live_next;
            res_status_reg <= res_status_next;
            res_start_reg  <= res_start_next;
            res_run_reg    <= res_run_next;
            res_seq_reg    <= res_seq_next;
            res_live_reg   <= res_live_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_start_reg  <= out_start_next;
            out_run_reg    <= out_run_next;
            out_seq_reg    <= out_seq_next;
            out_live_reg   <= out_live_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd <= map_mem[map_ra];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[alloc_start] <= need_reg;
        end
        len_rd <= len_mem[fstart_reg];
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign start_chunk    = out_start_reg;
    assign run_chunks     = out_run_reg;
    assign alloc_sequence = out_seq_reg;
    assign live_objects   = out_live_reg;

    a_commit_run_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> ((hit_data_reg & alloc_mask) == '0))
        else $error("granted run overlaps used chunks");

    a_commit_run_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> ((7'(hit_b_reg) + 7'(need_reg)) <= 7'(WORD_BITS)))
        else $error("granted run crosses a word boundary");

    a_commit_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |=> (seq_reg == $past(seq_reg) + SEQ_W'(1)))
        else $error("sequence counter did not advance on grant");

    a_live_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_COMMIT && state_reg != S_FREE_WR) |=> $stable(live_reg))
        else $error("live count changed outside grant or release");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && pend_reg) |-> (CNT_W'(pend_idx_reg) < words))
        else $error("scan evaluated a word beyond the active map");

endmodule
